// ===== design/assert_macros.svh =====
// Assertion macros for the design files; running_moving_average.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/rma_pkg.sv =====
// Package for the running moving average: defaults and sequencer states.
package rma_pkg;

  localparam int DEF_WINDOW_SIZE = 16;
  localparam int DEF_SAMPLE_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_DONE
  } rma_state_t;

endpackage

// ===== design/rma_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
module rma_div #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [STEP_W-1:0]     steps;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== design/running_moving_average.sv =====
// Top level of the running moving average over a ring store of samples.
//
//  channel  | handshake           | words
//  ---------+---------------------+--------------------------
//  in       | in_valid / in_stall | sample, sample_valid
//  out      | out_valid/out_stall | average
//
// An item goes through these steps in order: accept and store read, sum update and
// store write, divider load, divider steps (one per quotient bit), divider done,
// output load. The serial divider divides the sum by the fill count.
// Synchronous reset clears pointer, count, sum and control; the store is not
// cleared. in_stall is high while an item is in work; a result held by
// out_stall waits in the output register while the next item is taken, and
// the next output load waits until it leaves.
module running_moving_average #(
  parameter int WINDOW_SIZE = rma_pkg::DEF_WINDOW_SIZE,
  parameter int SAMPLE_BITS = rma_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          sample_valid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] average
);

  import rma_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int SUM_W = SAMPLE_BITS + CNT_W;

  rma_state_t state, state_next;

  logic [SAMPLE_BITS-1:0] window_store [WINDOW_SIZE];
  logic [SAMPLE_BITS-1:0] rd_data;

  logic [PTR_W-1:0]       wp;
  logic [CNT_W-1:0]       cnt;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       sum_next;
  logic [SAMPLE_BITS-1:0] smp;
  logic                   smp_ok;
  logic                   full;

  logic                   accept;
  logic                   update;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quo;
  logic [SUM_W-1:0]       sum_mag;
  logic [SUM_W-1:0]       quo_signed;
  logic                   out_free;
  logic                   load_out;

  assign accept   = in_valid && !in_stall;
  assign full     = (cnt == CNT_W'(WINDOW_SIZE));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SUM;
      ST_SUM:   state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    update    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:  in_stall  = 1'b0;
      ST_SUM:   update    = smp_ok;
      ST_START: div_start = 1'b1;
      ST_DONE:  load_out  = out_free;
      default:  in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ring store, one read or one write per cycle
  always_ff @(posedge clk) begin
    if (accept) rd_data <= window_store[wp];
    if (update) window_store[wp] <= smp;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp    <= sample;
      smp_ok <= sample_valid;
    end
  end

  always_comb begin
    sum_next = sum + {{CNT_W{smp[SAMPLE_BITS-1]}}, smp};
    if (full) sum_next = sum_next - {{CNT_W{rd_data[SAMPLE_BITS-1]}}, rd_data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      cnt <= '0;
      sum <= '0;
    end else if (update) begin
      sum <= sum_next;
      if (!full) cnt <= cnt + 1'b1;
      if (wp == PTR_W'(WINDOW_SIZE - 1)) wp <= '0;
      else                               wp <= wp + 1'b1;
    end
  end

  assign sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

  rma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo_signed = sum[SUM_W-1] ? (~div_quo + 1'b1) : div_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cnt == '0) average <= '0;
      else           average <= quo_signed[SAMPLE_BITS-1:0];
    end
  end

  `ASSERT_NEVER(a_cnt_range, cnt > CNT_W'(WINDOW_SIZE), "fill count past window size")
  `ASSERT_CLK(a_accept_to_sum, accept |=> (state == ST_SUM), "accept not followed by update")
  `ASSERT_CLK(a_done_in_div, div_done |-> (state == ST_DIV), "divider done outside divide")
  `ASSERT_CLK(a_wp_hold, (state != ST_SUM) |=> $stable(wp), "pointer moved outside update")
  `ASSERT_NEVER(a_load_full, load_out && out_valid && out_stall, "output overwritten while held")

endmodule
